// ===== hdl/tmpaf_pkg.sv =====
// Shared types, register indexes and helpers for the tile phase average fill block.
`default_nettype none

package tmpaf_pkg;

  localparam int PhaseW  = 4;
  localparam int SumW    = 12;
  localparam int CountW  = 5;
  localparam int QDepth  = 4;
  localparam int QPtrW   = 2;
  localparam int DivSteps = 12;

  typedef logic [2:0][7:0] pix_t;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_GRID_MODE    = 2'd0;
  localparam cfg_idx_t CFG_PRESENT_MASK = 2'd1;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    pix_t              pix;
    logic              last;
  } q_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } state_e;

  function automatic logic [CountW-1:0] tile_size(logic [1:0] mode, logic [CountW-1:0] cap);
    logic [CountW-1:0] n;
    n = 5'd2 << mode;
    return (n > cap) ? cap : n;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tile_missing_phase_average_fill.sv =====
// Top level of the tile missing-phase average fill block.
// Non-final phase: stored when the idle back end pops it from the queue, one item per cycle
// while the back end idles. Final phase: leaves the queue, masked sums over N phases, prep,
// a bit-serial divide (skipped when no phase is present), then N results at one per cycle
// unless the output stalls. N is the tile size; sum walk and divide set the tile-end cost.
// Reset clears control state and config; the tile store is undefined until written.
`default_nettype none

module tile_missing_phase_average_fill #(
  parameter int MAX_TILE_PIXELS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [tmpaf_pkg::PhaseW-1:0]  phase_i,
  input  wire logic [7:0]                    red_i,
  input  wire logic [7:0]                    green_i,
  input  wire logic [7:0]                    blue_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [tmpaf_pkg::PhaseW-1:0]       out_phase_o,
  output logic [7:0]                         out_red_o,
  output logic [7:0]                         out_green_o,
  output logic [7:0]                         out_blue_o,
  output logic                               filled_o,
  output logic                               no_samples_o,
  output logic                               tile_last_o
);
  import tmpaf_pkg::*;

  logic [1:0]         grid_mode_q;
  logic [15:0]        mask_q;
  logic [CountW-1:0]  size;
  logic               q_full, push, pop_valid, pop;
  q_item_t            push_item, pop_item;

  assign cfg_ready_o = 1'b1;
  assign size        = tile_size(grid_mode_q, CountW'(MAX_TILE_PIXELS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_mode_q <= '0;
      mask_q      <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_GRID_MODE:    grid_mode_q <= cfg_data_i[1:0];
        CFG_PRESENT_MASK: mask_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tmpaf_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .phase_i    (phase_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .size_i     (size),
    .q_full_i   (q_full),
    .push_o     (push),
    .item_o     (push_item)
  );

  tmpaf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_item_o  (pop_item)
  );

  tmpaf_back #(
    .MAX_TILE_PIXELS (MAX_TILE_PIXELS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .size_i       (size),
    .mask_i       (mask_q),
    .pop_valid_i  (pop_valid),
    .pop_o        (pop),
    .pop_item_i   (pop_item),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_phase_o  (out_phase_o),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .filled_o     (filled_o),
    .no_samples_o (no_samples_o),
    .tile_last_o  (tile_last_o)
  );

endmodule

`default_nettype wire

// ===== hdl/tmpaf_front.sv =====
// Front end: accepts pixel items, drops out-of-tile phases, tags the last phase.
`default_nettype none

module tmpaf_front (
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [tmpaf_pkg::PhaseW-1:0]     phase_i,
  input  wire logic [7:0]                       red_i,
  input  wire logic [7:0]                       green_i,
  input  wire logic [7:0]                       blue_i,
  input  wire logic [tmpaf_pkg::CountW-1:0]     size_i,
  input  wire logic                             q_full_i,
  output logic                                  push_o,
  output tmpaf_pkg::q_item_t                    item_o
);
  import tmpaf_pkg::*;

  logic [CountW-1:0] phase_ext;
  logic              in_tile;

  assign phase_ext  = {1'b0, phase_i};
  assign in_tile    = phase_ext < size_i;
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i && in_tile;

  always_comb begin
    item_o.phase = phase_i;
    item_o.pix   = {red_i, green_i, blue_i};
    item_o.last  = phase_ext == (size_i - 5'd1);
  end

endmodule

`default_nettype wire

// ===== hdl/tmpaf_queue.sv =====
// Short item queue between the front end and the back end.
`default_nettype none

module tmpaf_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire tmpaf_pkg::q_item_t push_item_i,
  output logic                    full_o,
  output logic                    pop_valid_o,
  input  wire logic               pop_i,
  output tmpaf_pkg::q_item_t      pop_item_o
);
  import tmpaf_pkg::*;

  q_item_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]    count_q;

  assign full_o      = count_q == (QPtrW + 1)'(QDepth);
  assign pop_valid_o = count_q != '0;
  assign pop_item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tmpaf_back.sv =====
// Back end: tile store, masked sums, serial divide and phase-order emit.
`default_nettype none

module tmpaf_back #(
  parameter int MAX_TILE_PIXELS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [tmpaf_pkg::CountW-1:0]  size_i,
  input  wire logic [15:0]                   mask_i,
  input  wire logic                          pop_valid_i,
  output logic                               pop_o,
  input  wire tmpaf_pkg::q_item_t            pop_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [tmpaf_pkg::PhaseW-1:0]       out_phase_o,
  output logic [7:0]                         out_red_o,
  output logic [7:0]                         out_green_o,
  output logic [7:0]                         out_blue_o,
  output logic                               filled_o,
  output logic                               no_samples_o,
  output logic                               tile_last_o
);
  import tmpaf_pkg::*;

  localparam int IdxW = $clog2(MAX_TILE_PIXELS);

  state_e                 state_q, state_d;
  pix_t                   store_q [MAX_TILE_PIXELS];
  logic [PhaseW-1:0]      k_q;
  logic [3:0]             step_q;
  logic [2:0][SumW-1:0]   sum_q;
  logic [CountW-1:0]      cnt_q;
  logic [2:0][SumW-1:0]   num_q, num_d;
  logic [2:0][3:0]        rem_q, rem_d;
  logic                   out_valid_q;
  logic [PhaseW-1:0]      out_phase_q;
  pix_t                   out_pix_q;
  logic                   out_filled_q, out_none_q, out_last_q;

  pix_t                   rd_pix, avg_pix, emit_pix;
  logic                   k_last, emit_load, none, fill;
  logic [CountW-1:0]      trial [3];

  assign rd_pix = store_q[k_q[IdxW-1:0]];
  assign k_last = {1'b0, k_q} == (size_i - 5'd1);
  assign none   = cnt_q == '0;
  assign fill   = !mask_i[k_q] && !none;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      avg_pix[c] = num_q[c][7:0];
      trial[c]   = {rem_q[c], num_q[c][SumW-1]};
      if (trial[c] >= cnt_q) begin
        rem_d[c] = 4'(trial[c] - cnt_q);
        num_d[c] = {num_q[c][SumW-2:0], 1'b1};
      end else begin
        rem_d[c] = trial[c][3:0];
        num_d[c] = {num_q[c][SumW-2:0], 1'b0};
      end
    end
    emit_pix = fill ? avg_pix : rd_pix;
  end

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    emit_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (pop_valid_i) begin
          pop_o = 1'b1;
          if (pop_item_i.last) state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        if (k_last) state_d = ST_PREP;
      end
      ST_PREP: begin
        state_d = none ? ST_EMIT : ST_DIV;
      end
      ST_DIV: begin
        if (step_q == 4'(DivSteps - 1)) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          emit_load = 1'b1;
          if (k_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      step_q      <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (pop_o && pop_item_i.last) begin
            k_q   <= '0;
            cnt_q <= '0;
            sum_q <= '0;
          end
        end
        ST_SUM: begin
          k_q <= k_last ? '0 : k_q + 1'b1;
          if (mask_i[k_q]) begin
            cnt_q <= cnt_q + 1'b1;
            for (int c = 0; c < 3; c++) begin
              sum_q[c] <= sum_q[c] + SumW'(rd_pix[c]);
            end
          end
        end
        ST_PREP: step_q <= '0;
        ST_DIV:  step_q <= step_q + 1'b1;
        ST_EMIT: begin
          if (emit_load) k_q <= k_last ? '0 : k_q + 1'b1;
        end
        default: ;
      endcase
      if (emit_load)        out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      store_q[pop_item_i.phase[IdxW-1:0]] <= pop_item_i.pix;
    end
    if (state_q == ST_PREP) begin
      num_q <= sum_q;
      rem_q <= '0;
    end else if (state_q == ST_DIV) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
    if (emit_load) begin
      out_phase_q  <= k_q;
      out_pix_q    <= emit_pix;
      out_filled_q <= fill;
      out_none_q   <= none;
      out_last_q   <= k_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_phase_o  = out_phase_q;
  assign out_red_o    = out_pix_q[2];
  assign out_green_o  = out_pix_q[1];
  assign out_blue_o   = out_pix_q[0];
  assign filled_o     = out_filled_q;
  assign no_samples_o = out_none_q;
  assign tile_last_o  = out_last_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> cnt_q != '0)
    else $error("divide running with zero sample count");

  a_sum_in_tile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SUM |-> {1'b0, k_q} < size_i)
    else $error("sum walk past tile end");

  a_fill_has_samples: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_filled_q |-> !out_none_q)
    else $error("filled item flagged with no samples");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load && k_last |=> state_q == ST_IDLE && out_valid_q && out_last_q)
    else $error("tile end not closed after last item");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for the tile missing-phase average fill block: directed and random tiles.
`timescale 1ns / 1ps

module tb_top;
  import tmpaf_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int SettleCycles = 12;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              filled;
    logic              no_samples;
    logic              tile_last;
  } fill_px_t;

  logic              clk = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [1:0]        cfg_index_i = '0;
  logic [15:0]       cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [PhaseW-1:0] phase_i = '0;
  logic [7:0]        red_i = '0;
  logic [7:0]        green_i = '0;
  logic [7:0]        blue_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [PhaseW-1:0] out_phase_o;
  logic [7:0]        out_red_o;
  logic [7:0]        out_green_o;
  logic [7:0]        out_blue_o;
  logic              filled_o;
  logic              no_samples_o;
  logic              tile_last_o;

  // predictor state
  logic [1:0]  grid_mode_q = '0;
  logic [15:0] present_mask_q = '0;
  rgb_t        tile_mem [16];
  logic        mem_written [16];
  fill_px_t    fill_expect_q [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  tile_missing_phase_average_fill dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .phase_i      (phase_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_phase_o  (out_phase_o),
    .out_red_o    (out_red_o),
    .out_green_o  (out_green_o),
    .out_blue_o   (out_blue_o),
    .filled_o     (filled_o),
    .no_samples_o (no_samples_o),
    .tile_last_o  (tile_last_o)
  );

  function automatic int tile_pixels();
    int n;
    n = 2 << grid_mode_q;
    if (n > 16) n = 16;
    return n;
  endfunction

  // never let a tile end read a store entry that was never written
  function automatic logic [PhaseW-1:0] safe_phase(int ph);
    int n;
    n = tile_pixels();
    if (ph == n - 1) begin
      for (int k = 0; k < n - 1; k++) begin
        if (!mem_written[k]) return PhaseW'(k);
      end
    end
    return PhaseW'(ph);
  endfunction

  function automatic logic [7:0] rand_chan();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic predict_fill(input logic [PhaseW-1:0] ph, input rgb_t px);
    int       n;
    logic [11:0] sum_r, sum_g, sum_b;
    logic [4:0]  cnt;
    rgb_t     avg;
    fill_px_t o;
    n = tile_pixels();
    if (int'(ph) >= n) return;
    tile_mem[ph] = px;
    mem_written[ph] = 1'b1;
    if (int'(ph) != n - 1) return;
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    cnt = '0;
    avg = '0;
    for (int k = 0; k < n; k++) begin
      if (present_mask_q[k]) begin
        sum_r += tile_mem[k].red;
        sum_g += tile_mem[k].green;
        sum_b += tile_mem[k].blue;
        cnt++;
      end
    end
    if (cnt != 0) begin
      avg.red   = 8'(sum_r / cnt);
      avg.green = 8'(sum_g / cnt);
      avg.blue  = 8'(sum_b / cnt);
    end
    for (int k = 0; k < n; k++) begin
      o.phase = PhaseW'(k);
      o.filled = !present_mask_q[k] && (cnt != 0);
      {o.red, o.green, o.blue} = o.filled ? avg : tile_mem[k];
      o.no_samples = (cnt == 0);
      o.tile_last = (k == n - 1);
      fill_expect_q.push_back(o);
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want, input int ph);
    if (got != want)
      report_mismatch($sformatf("%s at phase %0d: got %0d, expected %0d", name, ph, got, want));
  endtask

  always @(posedge clk) begin : check_results
    fill_px_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (fill_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected item, phase %0d", out_phase_o));
      end else begin
        want = fill_expect_q.pop_front();
        check_field("out_phase", out_phase_o, want.phase, want.phase);
        check_field("out_red", out_red_o, want.red, want.phase);
        check_field("out_green", out_green_o, want.green, want.phase);
        check_field("out_blue", out_blue_o, want.blue, want.phase);
        check_field("filled", filled_o, want.filled, want.phase);
        check_field("no_samples", no_samples_o, want.no_samples, want.phase);
        check_field("tile_last", tile_last_o, want.tile_last, want.phase);
      end
    end
  end

  // receiver: long hold-off on request, else random stall
  always @(posedge clk) begin
    if (hold_req > 0) begin
      out_stall_i <= 1'b1;
      hold_req--;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk);
    while (!cfg_ready_o) @(posedge clk);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_GRID_MODE) grid_mode_q = val[1:0];
    else present_mask_q = val;
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [PhaseW-1:0] ph, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    in_valid_i <= 1'b1;
    phase_i    <= ph;
    red_i      <= r;
    green_i    <= g;
    blue_i     <= b;
    @(posedge clk);
    while (in_stall_o) @(posedge clk);
    predict_fill(ph, '{red: r, green: g, blue: b});
  endtask

  // stop offering items, wait for every result, let the input queue drain
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (fill_expect_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic test_reset_pass_through();
    send_pixel(4'd5, 8'h12, 8'h34, 8'h56);
    send_pixel(4'd0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(4'd1, 8'h00, 8'h00, 8'h00);
    wait_idle();
  endtask

  task automatic test_full_tile();
    logic [7:0] v;
    write_reg(CFG_GRID_MODE, 16'hFFFF);
    write_reg(CFG_PRESENT_MASK, 16'h8001);
    for (int k = 0; k < 16; k++) begin
      v = (k == 0 || k == 15) ? 8'hFF : ((k % 3 == 0) ? 8'h00 : 8'hAA);
      send_pixel(PhaseW'(k), v, ~v, 8'(k * 17));
    end
    wait_idle();
  endtask

  task automatic test_overwrite_and_late_mask();
    write_reg(CFG_GRID_MODE, 16'h0001);
    write_reg(CFG_PRESENT_MASK, 16'hFFF5);
    send_pixel(4'd2, 8'd10, 8'd20, 8'd30);
    send_pixel(4'd2, 8'd200, 8'd100, 8'd50);
    send_pixel(4'd0, 8'd255, 8'd0, 8'd128);
    send_pixel(4'd1, 8'd1, 8'd2, 8'd3);
    wait_idle();
    write_reg(CFG_PRESENT_MASK, 16'h0006);
    send_pixel(4'd3, 8'd0, 8'd255, 8'd0);
    wait_idle();
  endtask

  task automatic test_random_tiles(input int idle_pct, input int stall_pct, input int budget);
    int sent;
    int n;
    int r;
    logic [1:0]  mode;
    logic [15:0] mask;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < budget) begin
      wait_idle();
      r = $urandom_range(0, 9);
      mode = (r < 2) ? 2'd0 : (r < 4) ? 2'd3 : 2'($urandom_range(0, 3));
      r = $urandom_range(0, 7);
      mask = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      write_reg(CFG_GRID_MODE, {14'($urandom_range(0, 16383)), mode});
      write_reg(CFG_PRESENT_MASK, mask);
      repeat ($urandom_range(1, 4)) begin
        n = tile_pixels();
        for (int k = 0; k < n; k++) begin
          r = $urandom_range(0, 19);
          if (r == 0 && n < 16)
            send_pixel(PhaseW'($urandom_range(n, 15)), rand_chan(), rand_chan(), rand_chan());
          if (r == 1) begin
            send_pixel(safe_phase($urandom_range(0, n - 1)), rand_chan(), rand_chan(),
                       rand_chan());
            sent++;
          end
          if (r == 2 && k == n - 1) begin
            wait_idle();
            write_reg(CFG_PRESENT_MASK, 16'($urandom_range(0, 65535)));
          end
          send_pixel(safe_phase(k), rand_chan(), rand_chan(), rand_chan());
          sent++;
        end
        if ($urandom_range(0, 5) == 0) wait_idle();
      end
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_idle();
    write_reg(CFG_GRID_MODE, 16'h0003);
    write_reg(CFG_PRESENT_MASK, 16'($urandom_range(0, 65535)));
    hold_req = 300;
    for (int k = 0; k < 48; k++)
      send_pixel(PhaseW'(k % 16), rand_chan(), rand_chan(), rand_chan());
    wait_idle();
  endtask

  initial begin
    for (int k = 0; k < 16; k++) mem_written[k] = 1'b0;
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_reset_pass_through();
    test_full_tile();
    test_overwrite_and_late_mask();
    test_random_tiles(25, 56, 90);
    test_random_tiles(56, 25, 90);
    test_backpressure();
    test_random_tiles(0, 0, 90);
    in_valid_i <= 1'b0;
    while (fill_expect_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tmpaf_pkg.sv
hdl/tmpaf_front.sv
hdl/tmpaf_queue.sv
hdl/tmpaf_back.sv
hdl/tile_missing_phase_average_fill.sv
bench/tb_top.sv
